// ----- rtl/core/dtp_pkg.sv -----
// ----------------------------------------------------------------------------
// Date-time text parser package
// Parse phases, character codes, field widths and the fraction weight table.
// ----------------------------------------------------------------------------
`default_nettype none

package dtp_pkg;

    typedef enum logic [3:0] {
        PH_YEAR   = 4'd0,
        PH_MONTH  = 4'd1,
        PH_DAY    = 4'd2,
        PH_HOUR   = 4'd3,
        PH_MINUTE = 4'd4,
        PH_SEC    = 4'd5,
        PH_AFTER  = 4'd6,
        PH_FRAC   = 4'd7,
        PH_TZSEEK = 4'd8,
        PH_TZHOUR = 4'd9,
        PH_TZGAP  = 4'd10,
        PH_TZMIN  = 4'd11,
        PH_IDLE   = 4'd12
    } phase_t;

    typedef enum logic [1:0] {
        TZ_NONE  = 2'd0,
        TZ_PLUS  = 2'd1,
        TZ_MINUS = 2'd2
    } tz_sign_t;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_DOT   = 8'h2E;

    localparam int FIELD_W  = 14;
    localparam int SMALL_W  = 7;
    localparam int NS_W     = 30;
    localparam int TZ_W     = 20;
    localparam int TDATA_W  = 104;

    function automatic logic [NS_W-1:0] ns_weight(input logic [3:0] idx);
        logic [NS_W-1:0] w;
        unique case (idx)
            4'd0:    w = 30'd100000000;
            4'd1:    w = 30'd10000000;
            4'd2:    w = 30'd1000000;
            4'd3:    w = 30'd100000;
            4'd4:    w = 30'd10000;
            4'd5:    w = 30'd1000;
            4'd6:    w = 30'd100;
            4'd7:    w = 30'd10;
            4'd8:    w = 30'd1;
            default: w = 30'd0;
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/datetime_text_parser.sv -----
// ----------------------------------------------------------------------------
// Date-time text parser
// Parses YYYY-MM-DD HH:MM:SS[.fraction][ ... +HH:MM] one character per item
// and gives the decoded fields when the last character arrives.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Item
// s_axis    in         one character, tlast on the final character
// m_axis    out        decoded date-time, tuser is the valid flag
//
// Every cycle one character can be taken while s_axis_tready is high; the
// parse state updates in the same cycle, and the last character loads a free
// entry of a two-entry output (result register plus skid register); characters
// keep flowing while a result waits; s_axis_tready falls only when both hold.
// Reset returns the parser to the start of the year field with no result.
`default_nettype none

module datetime_text_parser #(
    parameter int FRACTION_DIGITS = 9
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // [7:0] char_code
    input  wire logic [7:0]   s_axis_tdata,
    input  wire logic         s_axis_tlast,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // [13:0] year, [20:14] month, [27:21] day, [34:28] hour, [41:35] minute,
    // [48:42] second, [78:49] nanoseconds, [98:79] tz_offset_seconds, rest zero
    output logic [103:0]      m_axis_tdata,
    // [0] valid_res
    output logic              m_axis_tuser
);

    localparam int FRAC_LIMIT = (FRACTION_DIGITS < 9) ? FRACTION_DIGITS : 9;

    dtp_pkg::phase_t          phase_reg, phase_next;
    logic [3:0]               count_reg, count_next;
    logic [13:0]              acc_reg, acc_next;
    logic [13:0]              fields_reg [6];
    logic [13:0]              fields_next [6];
    logic [29:0]              frac_reg, frac_next;
    dtp_pkg::tz_sign_t        sign_reg, sign_next;
    logic [6:0]               tzh_reg, tzh_next;
    logic [6:0]               tzm_reg, tzm_next;

    logic                     out_valid_reg, skid_valid_reg;
    logic [103:0]             out_data_reg, skid_data_reg;
    logic                     out_user_reg, skid_user_reg;

    logic                     s_fire, res_fire, out_free;
    logic                     is_digit, go_on;
    logic [3:0]               digit;
    logic [3:0]               lim;
    logic [7:0]               sep;
    logic [29:0]              frac_term;
    logic [18:0]              tz_mag;
    logic [19:0]              tz_off;
    logic [103:0]             res_data;
    logic                     res_user;

    assign s_axis_tready = !skid_valid_reg;
    assign s_fire        = s_axis_tvalid && s_axis_tready;
    assign res_fire      = s_fire && s_axis_tlast;
    assign out_free      = !out_valid_reg || m_axis_tready;

    assign is_digit  = (s_axis_tdata >= dtp_pkg::CH_ZERO) && (s_axis_tdata <= dtp_pkg::CH_NINE);
    assign digit     = is_digit ? 4'(s_axis_tdata - dtp_pkg::CH_ZERO) : 4'd0;
    assign frac_term = 30'(digit) * dtp_pkg::ns_weight(count_reg);

    always_comb
    begin
        phase_next = phase_reg;
        count_next = count_reg;
        acc_next   = acc_reg;
        frac_next  = frac_reg;
        sign_next  = sign_reg;
        tzh_next   = tzh_reg;
        tzm_next   = tzm_reg;
        for (int i = 0; i < 6; i++)
        begin
            fields_next[i] = fields_reg[i];
        end
        go_on = 1'b1;
        lim   = (phase_reg == dtp_pkg::PH_YEAR) ? 4'd4 : 4'd2;
        if (phase_reg == dtp_pkg::PH_YEAR || phase_reg == dtp_pkg::PH_MONTH)
        begin
            sep = dtp_pkg::CH_DASH;
        end
        else if (phase_reg == dtp_pkg::PH_DAY)
        begin
            sep = dtp_pkg::CH_SPACE;
        end
        else
        begin
            sep = dtp_pkg::CH_COLON;
        end

        if (s_axis_tdata == dtp_pkg::CH_NUL)
        begin
            phase_next = dtp_pkg::PH_IDLE;
            go_on      = 1'b0;
        end
        else if (phase_reg <= dtp_pkg::PH_SEC)
        begin
            if (is_digit && count_reg < lim)
            begin
                acc_next   = 14'({acc_reg, 3'b000} + {acc_reg, 1'b0} + 17'(digit));
                count_next = count_reg + 4'd1;
                fields_next[phase_reg[2:0]] = acc_next;
                if (phase_reg == dtp_pkg::PH_SEC && count_next == 4'd2)
                begin
                    phase_next = dtp_pkg::PH_AFTER;
                end
                go_on = 1'b0;
            end
            else if (count_reg == 4'd0)
            begin
                phase_next = dtp_pkg::PH_IDLE;
                go_on      = 1'b0;
            end
            else if (phase_reg == dtp_pkg::PH_SEC)
            begin
                phase_next = dtp_pkg::PH_AFTER;
            end
            else
            begin
                if (s_axis_tdata == sep)
                begin
                    phase_next = dtp_pkg::phase_t'(phase_reg + 4'd1);
                    count_next = 4'd0;
                    acc_next   = 14'd0;
                end
                else
                begin
                    phase_next = dtp_pkg::PH_IDLE;
                end
                go_on = 1'b0;
            end
        end

        if (go_on && phase_next == dtp_pkg::PH_AFTER)
        begin
            if (s_axis_tdata == dtp_pkg::CH_DOT)
            begin
                phase_next = dtp_pkg::PH_FRAC;
                count_next = 4'd0;
                frac_next  = 30'd0;
                go_on      = 1'b0;
            end
            else
            begin
                phase_next = dtp_pkg::PH_TZSEEK;
            end
        end

        if (go_on && phase_next == dtp_pkg::PH_FRAC)
        begin
            if (is_digit)
            begin
                if (count_reg < 4'(FRAC_LIMIT))
                begin
                    frac_next  = frac_reg + frac_term;
                    count_next = count_reg + 4'd1;
                end
                go_on = 1'b0;
            end
            else
            begin
                phase_next = dtp_pkg::PH_TZSEEK;
            end
        end

        if (go_on)
        begin
            unique case (phase_next)
                dtp_pkg::PH_TZSEEK:
                begin
                    if (s_axis_tdata == dtp_pkg::CH_PLUS || s_axis_tdata == dtp_pkg::CH_DASH)
                    begin
                        sign_next  = (s_axis_tdata == dtp_pkg::CH_PLUS) ?
                                     dtp_pkg::TZ_PLUS : dtp_pkg::TZ_MINUS;
                        phase_next = dtp_pkg::PH_TZHOUR;
                        count_next = 4'd0;
                    end
                end
                dtp_pkg::PH_TZHOUR:
                begin
                    if (is_digit)
                    begin
                        if (count_reg == 4'd0)
                        begin
                            tzh_next   = 7'(digit);
                            count_next = 4'd1;
                        end
                        else
                        begin
                            tzh_next   = 7'({tzh_reg, 3'b000} + {tzh_reg, 1'b0} + 10'(digit));
                            phase_next = dtp_pkg::PH_TZGAP;
                        end
                    end
                    else
                    begin
                        phase_next = (count_reg == 4'd0) ? dtp_pkg::PH_IDLE : dtp_pkg::PH_TZGAP;
                    end
                end
                dtp_pkg::PH_TZGAP:
                begin
                    if (is_digit)
                    begin
                        tzm_next   = 7'(digit);
                        phase_next = dtp_pkg::PH_TZMIN;
                    end
                end
                dtp_pkg::PH_TZMIN:
                begin
                    if (is_digit)
                    begin
                        tzm_next = 7'({tzm_reg, 3'b000} + {tzm_reg, 1'b0} + 10'(digit));
                    end
                    phase_next = dtp_pkg::PH_IDLE;
                end
                default:
                begin
                end
            endcase
        end
    end

    // Offset magnitude uses constant multiplies of seven-bit values.
    assign tz_mag = 19'(19'(tzh_next) * 19'd3600) + 19'(19'(tzm_next) * 19'd60);

    always_comb
    begin
        unique case (sign_next)
            dtp_pkg::TZ_PLUS:  tz_off = {1'b0, tz_mag};
            dtp_pkg::TZ_MINUS: tz_off = 20'(-{1'b0, tz_mag});
            default:           tz_off = 20'd0;
        endcase
        res_user = (fields_next[2] != 14'd0);
        if (res_user)
        begin
            res_data = {5'd0, tz_off, frac_next,
                        fields_next[5][6:0], fields_next[4][6:0], fields_next[3][6:0],
                        fields_next[2][6:0], fields_next[1][6:0], fields_next[0]};
        end
        else
        begin
            res_data = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= dtp_pkg::PH_YEAR;
            count_reg <= 4'd0;
            acc_reg   <= 14'd0;
            frac_reg  <= 30'd0;
            sign_reg  <= dtp_pkg::TZ_NONE;
            tzh_reg   <= 7'd0;
            tzm_reg   <= 7'd0;
            for (int i = 0; i < 6; i++)
            begin
                fields_reg[i] <= 14'd0;
            end
        end
        else if (s_fire)
        begin
            if (s_axis_tlast)
            begin
                phase_reg <= dtp_pkg::PH_YEAR;
                count_reg <= 4'd0;
                acc_reg   <= 14'd0;
                frac_reg  <= 30'd0;
                sign_reg  <= dtp_pkg::TZ_NONE;
                tzh_reg   <= 7'd0;
                tzm_reg   <= 7'd0;
                for (int i = 0; i < 6; i++)
                begin
                    fields_reg[i] <= 14'd0;
                end
            end
            else
            begin
                phase_reg <= phase_next;
                count_reg <= count_next;
                acc_reg   <= acc_next;
                frac_reg  <= frac_next;
                sign_reg  <= sign_next;
                tzh_reg   <= tzh_next;
                tzm_reg   <= tzm_next;
                for (int i = 0; i < 6; i++)
                begin
                    fields_reg[i] <= fields_next[i];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= res_fire;
            end
        end
        else if (res_fire)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_data_reg <= skid_data_reg;
                out_user_reg <= skid_user_reg;
            end
            else if (res_fire)
            begin
                out_data_reg <= res_data;
                out_user_reg <= res_user;
            end
        end
        else if (res_fire)
        begin
            skid_data_reg <= res_data;
            skid_user_reg <= res_user;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;

endmodule

`default_nettype wire
